// ===== src/rmct_pkg.sv =====
// ----------------------------------------------------------------------------
// rmct_pkg
// Shared types and constants of the reference-counted MRU tag store.
// ----------------------------------------------------------------------------
package rmct_pkg;

  localparam int unsigned KEY_W   = 40;
  localparam int unsigned HDL_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned KIND_W  = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    K_HIT      = 3'd0,
    K_INSERTED = 3'd1,
    K_LOADFAIL = 3'd2,
    K_EVICTED  = 3'd3,
    K_RELEASED = 3'd4,
    K_NOTFOUND = 3'd5,
    K_FULL     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_MTF     = 2'd1,
    OP_INSERT  = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LOOK  = 2'd1,
    S_EVICT = 2'd2
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
  } ctrl_t;

  typedef struct packed {
    logic key_found;
    logic hdl_found;
  } chain_t;

  typedef struct packed {
    logic [HDL_W-1:0] hit_hd;
    logic [CNT_W-1:0] hit_ct;
    logic [CNT_W-1:0] rel_ct;
    logic             tail_zero;
    logic [HDL_W-1:0] tail_hd;
  } report_t;

endpackage

// ===== src/refcounted_mru_cache_tags.sv =====
// ----------------------------------------------------------------------------
// refcounted_mru_cache_tags
// Move-to-front tag store with use counts, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel: tuser selects a lookup or a release,
// tdata carries the key, the handle and the load status. Each command gives
// one or more result transactions on m_axis; tlast marks the final one, and
// tuser gives the result kind. The limit register is written through
// cfg_we_i and cfg_wdata_i; the user must write it only while the block is
// idle, which the block itself does not enforce. A command is registered
// on acceptance and compared against all cells in the next cycle. A hit or a
// release places its single result in the output register from the compare
// state once that register is free. A miss then evicts tail entries, one tail
// cell per cycle while the output register is free, and then gives the final
// result; the number of evictions is at most MAX_ENTRIES.
// Reset empties the store and sets the limit to 8. When the receiver stalls,
// the pending result waits in the output register and the block holds its
// work until the register is free; a new command can be taken while the last
// result of the previous one still waits.
// ----------------------------------------------------------------------------
module refcounted_mru_cache_tags #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rmct_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // obj_num[23:0], obj_gen[39:24], font_handle[55:40], load_ok[56], zero fill
  input  logic [63:0]                  s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // handle[15:0], use_count[31:16]
  output logic [31:0]                  m_axis_tdata,
  // kind[2:0]
  output logic [rmct_pkg::KIND_W-1:0]  m_axis_tuser,
  output logic                         m_axis_tlast
);
  import rmct_pkg::*;

  localparam int unsigned TW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (TW > LIMIT_W) ? TW : LIMIT_W;

  state_e state_q, state_d;
  logic [TW-1:0]      total_q, total_d;
  logic [LIMIT_W-1:0] limit_q;

  logic             cmd_q, ok_q;
  logic [KEY_W-1:0] key_q;
  logic [HDL_W-1:0] hdl_q;

  logic             out_valid_q, out_valid_d;
  logic [HDL_W-1:0] out_hd_q;
  logic [CNT_W-1:0] out_ct_q;
  kind_e            out_kind_q;
  logic             out_last_q;

  logic             emit, emit_last;
  kind_e            emit_kind;
  logic [HDL_W-1:0] emit_hd;
  logic [CNT_W-1:0] emit_ct;

  ctrl_t   ctrl;
  entry_t  front;
  entry_t  entry_w [MAX_ENTRIES];
  chain_t  chain_w [MAX_ENTRIES+1];
  report_t rep_w   [MAX_ENTRIES];
  report_t rep;

  logic             slot_free, in_acc, evict_cond, full;
  logic [CNT_W-1:0] hit_inc;

  assign chain_w[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    entry_t prev;
    if (g == 0) begin : g_head
      assign prev = front;
    end else begin : g_body
      assign prev = entry_w[g-1];
    end
    rmct_cell #(
      .Idx    (g),
      .TotalW (TW)
    ) u_cell (
      .clk_i   (clk_i),
      .total_i (total_q),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .chain_i (chain_w[g]),
      .chain_o (chain_w[g+1]),
      .entry_o (entry_w[g]),
      .rep_o   (rep_w[g])
    );
  end

  always_comb begin
    rep = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rep = report_t'(rep | rep_w[i]);
    end
  end

  assign slot_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign hit_inc    = (rep.hit_ct == CNT_MAX) ? rep.hit_ct : rep.hit_ct + 1'b1;
  assign full       = total_q == TW'(MAX_ENTRIES);
  assign evict_cond = (total_q != '0) && (CW'(total_q) >= CW'(limit_q)) && rep.tail_zero;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd_q || chain_w[MAX_ENTRIES].key_found) begin
          if (slot_free) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: begin
        if (slot_free && !evict_cond) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op     = OP_NONE;
    ctrl.key    = key_q;
    ctrl.handle = hdl_q;
    front.key    = key_q;
    front.handle = hdl_q;
    front.count  = CNT_W'(1);
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_kind = K_HIT;
    emit_hd   = '0;
    emit_ct   = '0;
    total_d   = total_q;
    case (state_q)
      S_LOOK: begin
        if (slot_free) begin
          if (cmd_q) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_hd   = hdl_q;
            if (chain_w[MAX_ENTRIES].hdl_found) begin
              ctrl.op   = OP_RELEASE;
              emit_kind = K_RELEASED;
              emit_ct   = rep.rel_ct;
            end else begin
              emit_kind = K_NOTFOUND;
            end
          end else if (chain_w[MAX_ENTRIES].key_found) begin
            ctrl.op      = OP_MTF;
            front.handle = rep.hit_hd;
            front.count  = hit_inc;
            emit         = 1'b1;
            emit_last    = 1'b1;
            emit_kind    = K_HIT;
            emit_hd      = rep.hit_hd;
            emit_ct      = hit_inc;
          end
        end
      end
      S_EVICT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (evict_cond) begin
            emit_kind = K_EVICTED;
            emit_hd   = rep.tail_hd;
            total_d   = total_q - 1'b1;
          end else begin
            emit_last = 1'b1;
            if (!ok_q) begin
              emit_kind = K_LOADFAIL;
            end else if (full) begin
              emit_kind = K_FULL;
              emit_hd   = hdl_q;
            end else begin
              ctrl.op   = OP_INSERT;
              emit_kind = K_INSERTED;
              emit_hd   = hdl_q;
              emit_ct   = CNT_W'(1);
              total_d   = total_q + 1'b1;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser[0];
      key_q <= {s_axis_tdata[23:0], s_axis_tdata[39:24]};
      hdl_q <= s_axis_tdata[55:40];
      ok_q  <= s_axis_tdata[56];
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_hd_q   <= emit_hd;
      out_ct_q   <= emit_ct;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ct_q, out_hd_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/rmct_cell.sv =====
// ----------------------------------------------------------------------------
// rmct_cell
// One slot of the tag store chain: holds an entry, compares it against the
// broadcast key or handle and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module rmct_cell #(
  parameter int unsigned Idx    = 0,
  parameter int unsigned TotalW = 5
) (
  input  logic                 clk_i,
  input  logic [TotalW-1:0]    total_i,
  input  rmct_pkg::ctrl_t      ctrl_i,
  input  rmct_pkg::entry_t     prev_i,
  input  rmct_pkg::chain_t     chain_i,
  output rmct_pkg::chain_t     chain_o,
  output rmct_pkg::entry_t     entry_o,
  output rmct_pkg::report_t    rep_o
);
  import rmct_pkg::*;

  entry_t entry_q, entry_d;
  logic   load;
  logic   valid, is_tail, in_shift;
  logic   key_match, hdl_match, key_first, hdl_first;
  logic [CNT_W-1:0] dec_ct;

  assign valid     = total_i > TotalW'(Idx);
  assign is_tail   = total_i == TotalW'(Idx + 1);
  assign in_shift  = TotalW'(Idx) <= total_i;
  assign key_match = valid && (entry_q.key == ctrl_i.key);
  assign hdl_match = valid && (entry_q.handle == ctrl_i.handle);
  assign key_first = key_match && !chain_i.key_found;
  assign hdl_first = hdl_match && !chain_i.hdl_found;
  assign dec_ct    = (entry_q.count == '0) ? '0 : entry_q.count - 1'b1;

  assign chain_o.key_found = chain_i.key_found | key_match;
  assign chain_o.hdl_found = chain_i.hdl_found | hdl_match;

  always_comb begin
    load    = 1'b0;
    entry_d = prev_i;
    case (ctrl_i.op)
      OP_MTF: begin
        load = !chain_i.key_found;
      end
      OP_INSERT: begin
        load = in_shift;
      end
      OP_RELEASE: begin
        load          = hdl_first;
        entry_d       = entry_q;
        entry_d.count = dec_ct;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o          = entry_q;
  assign rep_o.hit_hd     = key_first ? entry_q.handle : '0;
  assign rep_o.hit_ct     = key_first ? entry_q.count : '0;
  assign rep_o.rel_ct     = hdl_first ? dec_ct : '0;
  assign rep_o.tail_zero  = is_tail && (entry_q.count == '0);
  assign rep_o.tail_hd    = is_tail ? entry_q.handle : '0;

endmodule

// ===== tb/refcounted_mru_cache_tags_test.sv =====
// ----------------------------------------------------------------------------
// refcounted_mru_cache_tags_test
// Self-checking regression for the move-to-front tag store with use counts.
// ----------------------------------------------------------------------------
// Commands are sent on the s_axis channel with random gaps while the m_axis
// receiver stalls at random. A behavioral copy of the tag store, kept in this
// module, turns each accepted command into the result transactions it must
// produce, and every result that leaves the block is compared field by field
// with the oldest one still pending. The run starts with directed sequences
// for hits, releases, duplicate handles, a full store, a maximal eviction
// burst and the limit extremes. It then runs random traffic over several limit
// settings, the last of them without gaps or stalls.
// ----------------------------------------------------------------------------
module refcounted_mru_cache_tags_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmct_pkg::*;

  localparam int SLOTS           = 16;
  localparam int POOL            = 24;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 84;
  localparam int DRAIN_CYCLES    = 24;
  localparam int STALL_LIMIT     = 2000;

  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    kind_e            kind;
    logic [HDL_W-1:0] handle;
    logic [CNT_W-1:0] use_count;
    logic             last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata;
  logic [0:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [31:0]        m_axis_tdata;
  logic [KIND_W-1:0]  m_axis_tuser;
  logic               m_axis_tlast;

  logic [KEY_W-1:0]   tag_key    [SLOTS];
  logic [HDL_W-1:0]   tag_handle [SLOTS];
  logic [CNT_W-1:0]   tag_count  [SLOTS];
  int                 tag_total;
  logic [LIMIT_W-1:0] tag_limit;

  result_t            pending_results [$];
  result_t            oldest;
  logic [KEY_W-1:0]   key_pool [POOL];
  int                 error_count = 0;
  int                 gap_pct;
  int                 stall_pct;

  refcounted_mru_cache_tags #(
    .MAX_ENTRIES(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_result(input kind_e kind, input logic [HDL_W-1:0] hdl,
                                      input logic [CNT_W-1:0] cnt);
    result_t r;
    r.kind      = kind;
    r.handle    = hdl;
    r.use_count = cnt;
    r.last      = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void shift_toward_tail(input int upto);
    int i;
    for (i = upto; i > 0; i--) begin
      tag_key[i]    = tag_key[i-1];
      tag_handle[i] = tag_handle[i-1];
      tag_count[i]  = tag_count[i-1];
    end
  endfunction

  function automatic void predict_results(input logic cmd, input logic [KEY_W-1:0] key,
                                          input logic [HDL_W-1:0] hdl, input logic ok);
    int               i;
    int               slot;
    logic [HDL_W-1:0] hit_hdl;
    logic [CNT_W-1:0] hit_cnt;
    result_t          r;
    slot = -1;
    if (cmd == CMD_RELEASE) begin
      for (i = tag_total - 1; i >= 0; i--) begin
        if (tag_handle[i] == hdl) slot = i;
      end
      if (slot >= 0) begin
        if (tag_count[slot] != '0) tag_count[slot] = tag_count[slot] - 1'b1;
        push_result(K_RELEASED, hdl, tag_count[slot]);
      end else begin
        push_result(K_NOTFOUND, hdl, '0);
      end
    end else begin
      for (i = tag_total - 1; i >= 0; i--) begin
        if (tag_key[i] == key) slot = i;
      end
      if (slot >= 0) begin
        hit_hdl = tag_handle[slot];
        hit_cnt = tag_count[slot];
        if (hit_cnt != CNT_MAX) hit_cnt = hit_cnt + 1'b1;
        shift_toward_tail(slot);
        tag_key[0]    = key;
        tag_handle[0] = hit_hdl;
        tag_count[0]  = hit_cnt;
        push_result(K_HIT, hit_hdl, hit_cnt);
      end else begin
        while (tag_total > 0 && tag_total >= int'(tag_limit) &&
               tag_count[tag_total-1] == '0) begin
          tag_total--;
          push_result(K_EVICTED, tag_handle[tag_total], '0);
        end
        if (!ok) begin
          push_result(K_LOADFAIL, '0, '0);
        end else if (tag_total >= SLOTS) begin
          push_result(K_FULL, hdl, '0);
        end else begin
          shift_toward_tail(tag_total);
          tag_key[0]    = key;
          tag_handle[0] = hdl;
          tag_count[0]  = 16'd1;
          tag_total++;
          push_result(K_INSERTED, hdl, 16'd1);
        end
      end
    end
    r = pending_results.pop_back();
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  task automatic issue_command(input logic cmd, input logic [KEY_W-1:0] key,
                               input logic [HDL_W-1:0] hdl, input logic ok);
    int gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, ok, hdl, key[15:0], key[KEY_W-1:16]};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_results(cmd, key, hdl, ok);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tag_limit = value;
  endtask

  task automatic send_random_item();
    logic [31:0]      r_hi;
    logic [31:0]      r_lo;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] hdl;
    int               sel;
    r_hi = $urandom;
    r_lo = $urandom;
    sel  = $urandom_range(0, 99);
    if (sel < 40) begin
      if (tag_total != 0 && $urandom_range(0, 9) < 8) begin
        hdl = tag_handle[$urandom_range(0, tag_total - 1)];
      end else begin
        hdl = r_hi[31:16];
      end
      issue_command(CMD_RELEASE, {r_hi[7:0], r_lo}, hdl, r_hi[8]);
    end else begin
      if (sel < 90) begin
        key = key_pool[$urandom_range(0, POOL - 1)];
      end else begin
        key = {r_hi[7:0], r_lo};
      end
      if (r_hi[11:9] == 3'd0) begin
        hdl = {12'd0, r_hi[15:12]};
      end else begin
        hdl = r_hi[31:16];
      end
      issue_command(CMD_LOOKUP, key, hdl, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic test_hit_and_release();
    issue_command(CMD_LOOKUP, {24'hFFFFFF, 16'hFFFF}, 16'hFFFF, 1'b1);
    issue_command(CMD_LOOKUP, {24'hFFFFFF, 16'hFFFF}, 16'h1234, 1'b1);
    issue_command(CMD_LOOKUP, {24'h000000, 16'h0000}, 16'h0000, 1'b1);
    issue_command(CMD_LOOKUP, {24'hFFFFFF, 16'h0000}, 16'h0001, 1'b0);
    issue_command(CMD_RELEASE, {24'hFFFFFF, 16'hFFFF}, 16'hFFFF, 1'b1);
    issue_command(CMD_RELEASE, {24'h000000, 16'h0000}, 16'hFFFF, 1'b0);
    issue_command(CMD_RELEASE, {24'h123456, 16'h789A}, 16'hFFFF, 1'b1);
    issue_command(CMD_RELEASE, {24'h000000, 16'h0000}, 16'hBEEF, 1'b0);
    issue_command(CMD_RELEASE, {24'hFFFFFF, 16'hFFFF}, 16'h0000, 1'b0);
  endtask

  task automatic test_store_full();
    int n;
    int i;
    write_limit(5'd31);
    n = 0;
    while (tag_total < SLOTS) begin
      issue_command(CMD_LOOKUP, {24'h800000 + n[23:0], n[15:0]}, 16'h0100 + n[15:0], 1'b1);
      n++;
    end
    issue_command(CMD_LOOKUP, {24'h7FFFFF, 16'h8000}, 16'hCAFE, 1'b1);
    issue_command(CMD_LOOKUP, {24'h7FFFFF, 16'h8000}, 16'hCAFE, 1'b0);
    for (i = 0; i < tag_total; i++) begin
      if (tag_count[i] != '0) issue_command(CMD_RELEASE, '0, tag_handle[i], 1'b0);
    end
    write_limit(5'd1);
    issue_command(CMD_LOOKUP, {24'h0F0F0F, 16'hF0F0}, 16'h5555, 1'b0);
  endtask

  task automatic test_duplicate_handles();
    write_limit(5'd0);
    issue_command(CMD_LOOKUP, {24'h000001, 16'h0001}, 16'h0005, 1'b1);
    issue_command(CMD_LOOKUP, {24'h000002, 16'h0002}, 16'h0005, 1'b1);
    issue_command(CMD_RELEASE, {24'h000001, 16'h0001}, 16'h0005, 1'b1);
    issue_command(CMD_LOOKUP, {24'h000001, 16'h0001}, 16'hAAAA, 1'b0);
    issue_command(CMD_RELEASE, '0, 16'h0005, 1'b0);
    issue_command(CMD_RELEASE, '0, 16'h0005, 1'b0);
    issue_command(CMD_LOOKUP, {24'h000003, 16'h0003}, 16'h0006, 1'b1);
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    for (n = 0; n < POOL; n++) begin
      r_hi = $urandom;
      r_lo = $urandom;
      key_pool[n] = {r_hi[7:0], r_lo};
    end
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_limit(LIMIT_RESET);
          gap_pct   = 30;
          stall_pct = 30;
        end
        1: begin
          r_hi = $urandom_range(1, 16);
          write_limit(r_hi[LIMIT_W-1:0]);
          gap_pct   = 40;
          stall_pct = 15;
        end
        2: begin
          write_limit(5'd2);
          gap_pct   = 50;
          stall_pct = 50;
        end
        3: begin
          r_hi = $urandom_range(17, 31);
          write_limit(r_hi[LIMIT_W-1:0]);
          gap_pct   = 20;
          stall_pct = 40;
        end
        default: begin
          write_limit(5'd16);
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
        send_random_item();
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none pending: kind %0d handle 0x%0h",
               m_axis_tuser, m_axis_tdata[15:0]);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("kind", oldest.kind, m_axis_tuser);
        check_field("handle", oldest.handle, m_axis_tdata[15:0]);
        check_field("use_count", oldest.use_count, m_axis_tdata[31:16]);
        check_field("last", oldest.last, m_axis_tlast);
      end
    end
  end

  initial begin : rx_stall
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("refcounted_mru_cache_tags regression: fail");
    $finish;
  end

  initial begin : main
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOOKUP;
    tag_total     = 0;
    tag_limit     = LIMIT_RESET;
    gap_pct       = 25;
    stall_pct     = 25;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hit_and_release();
    test_store_full();
    test_duplicate_handles();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("refcounted_mru_cache_tags regression: pass");
    end else begin
      $display("refcounted_mru_cache_tags regression: fail");
    end
    $finish;
  end

endmodule
